// ----- src/mlr_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and zone mapping functions for the line rasterizer
package mlr_pkg;

	localparam int COORD_BITS = 12;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int EAST_BITS  = COORD_BITS + 2;
	localparam int DEC_BITS   = COORD_BITS + 3;

	localparam logic ACTION_START   = 1'b0;
	localparam logic ACTION_ADVANCE = 1'b1;

	localparam logic [2:0] ZONE0 = 3'd0;
	localparam logic [2:0] ZONE1 = 3'd1;
	localparam logic [2:0] ZONE2 = 3'd2;
	localparam logic [2:0] ZONE3 = 3'd3;
	localparam logic [2:0] ZONE4 = 3'd4;
	localparam logic [2:0] ZONE5 = 3'd5;
	localparam logic [2:0] ZONE6 = 3'd6;
	localparam logic [2:0] ZONE7 = 3'd7;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic   action;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} line_req_t;

	typedef struct packed {
		coord_t     pixel_x;
		coord_t     pixel_y;
		logic [2:0] octant;
		logic       final_pixel;
	} pixel_t;

	// set-up results handed from the front part to the walker
	typedef struct packed {
		logic                        action;
		logic [2:0]                  zone;
		coord_t                      walk_x;
		coord_t                      walk_y;
		coord_t                      stop_x;
		logic signed [DEC_BITS-1:0]  decision;
		logic signed [EAST_BITS-1:0] east_step;
		logic signed [DEC_BITS-1:0]  ne_step;
		coord_t                      first_x;
		coord_t                      first_y;
		logic                        first_last;
	} step_cmd_t;

	typedef struct packed {
		coord_t a;
		coord_t b;
	} coord_pair_t;

	function automatic coord_pair_t to_zone0(logic [2:0] zone, coord_t x, coord_t y);
		coord_pair_t r;
		case (zone)
			ZONE0: r = '{a: x, b: y};
			ZONE1: r = '{a: y, b: x};
			ZONE2: r = '{a: y, b: -x};
			ZONE3: r = '{a: -x, b: y};
			ZONE4: r = '{a: -x, b: -y};
			ZONE5: r = '{a: -y, b: -x};
			ZONE6: r = '{a: -y, b: x};
			default: r = '{a: x, b: -y};
		endcase
		return r;
	endfunction

	function automatic coord_pair_t from_zone0(logic [2:0] zone, coord_t u, coord_t v);
		coord_pair_t r;
		case (zone)
			ZONE0: r = '{a: u, b: v};
			ZONE1: r = '{a: v, b: u};
			ZONE2: r = '{a: -v, b: u};
			ZONE3: r = '{a: -u, b: v};
			ZONE4: r = '{a: -u, b: -v};
			ZONE5: r = '{a: -v, b: -u};
			ZONE6: r = '{a: v, b: -u};
			default: r = '{a: u, b: -v};
		endcase
		return r;
	endfunction

endpackage

// ----- src/midpoint_line_rasterizer.sv -----
`timescale 1ns / 1ps
// top: midpoint line rasterizer, eight-zone symmetry, one pixel per unstalled clock
// path: a request passes the classify stage, set-up stage, command queue and
//   output register before its pixel appears on the output
// throughput: one request and one pixel per cycle while pixel_ready holds; the
//   walker updates the decision value and steps the position for each pixel
// reset: arst_n clears all valid flags, empties the queue and drops any active line
module midpoint_line_rasterizer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  mlr_pkg::line_req_t req,
	output logic               pixel_valid,
	input  logic               pixel_ready,
	output mlr_pkg::pixel_t    pixel
);
	import mlr_pkg::*;

	logic front_valid;
	logic front_ready;
	step_cmd_t front_cmd;
	logic queue_valid;
	logic queue_ready;
	step_cmd_t queue_cmd;

	mlr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	mlr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_data   (queue_cmd)
	);

	mlr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (queue_valid),
		.cmd_ready   (queue_ready),
		.cmd         (queue_cmd),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel)
	);

endmodule

// ----- src/mlr_front.sv -----
`timescale 1ns / 1ps
// front part: takes requests, classifies the zone and sets up the decision terms
module mlr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  mlr_pkg::line_req_t req,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output mlr_pkg::step_cmd_t cmd
);
	import mlr_pkg::*;

	typedef struct packed {
		logic       action;
		logic [2:0] zone;
		coord_t     x0;
		coord_t     y0;
		coord_t     x1;
		coord_t     y1;
	} classed_t;

	// most negative code folds onto its neighbor so every mirror fits
	function automatic coord_t clamp_coord(coord_t c);
		coord_t r;
		r = c;
		if (c == {1'b1, {(COORD_BITS-1){1'b0}}}) begin
			r = {1'b1, {(COORD_BITS-2){1'b0}}, 1'b1};
		end
		return r;
	endfunction

	classed_t classed;
	classed_t classed_s1;
	logic valid_s1;
	logic ready_s1;
	logic ready_s2;

	logic signed [DIFF_BITS-1:0] dx;
	logic signed [DIFF_BITS-1:0] dy;
	logic [DIFF_BITS-1:0] abs_dx;
	logic [DIFF_BITS-1:0] abs_dy;
	logic flat;
	logic dx_neg;
	logic dy_neg;
	logic dx_le0;
	logic dy_le0;

	// stage 1: clamp and classify
	always_comb begin
		classed.action = req.action;
		classed.x0 = clamp_coord(req.start_x);
		classed.y0 = clamp_coord(req.start_y);
		classed.x1 = clamp_coord(req.end_x);
		classed.y1 = clamp_coord(req.end_y);
		dx = DIFF_BITS'(classed.x1) - DIFF_BITS'(classed.x0);
		dy = DIFF_BITS'(classed.y1) - DIFF_BITS'(classed.y0);
		dx_neg = dx[DIFF_BITS-1];
		dy_neg = dy[DIFF_BITS-1];
		dx_le0 = dx_neg || (dx == '0);
		dy_le0 = dy_neg || (dy == '0);
		abs_dx = dx_neg ? -dx : dx;
		abs_dy = dy_neg ? -dy : dy;
		flat = abs_dx > abs_dy;
		if (!dx_neg && !dy_neg) begin
			classed.zone = flat ? ZONE0 : ZONE1;
		end else if (dx_le0 && !dy_neg) begin
			classed.zone = flat ? ZONE3 : ZONE2;
		end else if (dx_le0 && dy_le0) begin
			classed.zone = flat ? ZONE4 : ZONE5;
		end else begin
			classed.zone = flat ? ZONE7 : ZONE6;
		end
	end

	assign ready_s1 = !valid_s1 || ready_s2;
	assign req_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && ready_s1) begin
			classed_s1 <= classed;
		end
	end

	// stage 2: map into zone 0 and build the decision terms
	coord_pair_t p0;
	coord_pair_t p1;
	logic signed [DIFF_BITS-1:0] du;
	logic signed [DIFF_BITS-1:0] dv;
	logic signed [EAST_BITS-1:0] dv_minus_du;
	step_cmd_t setup;
	step_cmd_t cmd_s2;
	logic valid_s2;

	always_comb begin
		p0 = to_zone0(classed_s1.zone, classed_s1.x0, classed_s1.y0);
		p1 = to_zone0(classed_s1.zone, classed_s1.x1, classed_s1.y1);
		du = DIFF_BITS'(p1.a) - DIFF_BITS'(p0.a);
		dv = DIFF_BITS'(p1.b) - DIFF_BITS'(p0.b);
		dv_minus_du = EAST_BITS'(dv) - EAST_BITS'(du);
		setup.action = classed_s1.action;
		setup.zone = classed_s1.zone;
		setup.walk_x = p0.a;
		setup.walk_y = p0.b;
		setup.stop_x = p1.a;
		setup.east_step = {dv, 1'b0};
		setup.ne_step = {dv_minus_du, 1'b0};
		setup.decision = DEC_BITS'(setup.east_step) - DEC_BITS'(du);
		setup.first_x = classed_s1.x0;
		setup.first_y = classed_s1.y0;
		setup.first_last = du == '0;
	end

	assign ready_s2 = !valid_s2 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			cmd_s2 <= setup;
		end
	end

	assign cmd_valid = valid_s2;
	assign cmd = cmd_s2;

endmodule

// ----- src/mlr_queue.sv -----
`timescale 1ns / 1ps
// short command queue between the set-up front and the pixel walker
module mlr_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  mlr_pkg::step_cmd_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output mlr_pkg::step_cmd_t pop_data
);
	import mlr_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	step_cmd_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push_fire;
	logic pop_fire;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = slot_q[rd_ptr_q];
	assign push_fire = push_valid && push_ready;
	assign pop_fire = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_fire, pop_fire})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_fire && !push_fire) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not drop on pop");

endmodule

// ----- src/mlr_back.sv -----
`timescale 1ns / 1ps
// back part: holds the active line, steps the decision value, registers pixels
module mlr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  mlr_pkg::step_cmd_t cmd,
	output logic               pixel_valid,
	input  logic               pixel_ready,
	output mlr_pkg::pixel_t    pixel
);
	import mlr_pkg::*;

	logic active_q;
	coord_t walk_x_q;
	coord_t walk_y_q;
	coord_t stop_x_q;
	logic signed [DEC_BITS-1:0] decision_q;
	logic signed [EAST_BITS-1:0] east_q;
	logic signed [DEC_BITS-1:0] ne_q;
	logic [2:0] zone_q;
	logic out_valid_q;
	pixel_t pixel_q;

	logic take;
	logic is_start;
	logic produce;
	logic step_ne;
	coord_t next_x;
	coord_t next_y;
	logic signed [DEC_BITS-1:0] next_dec;
	logic adv_last;
	coord_pair_t adv_xy;

	assign cmd_ready = !out_valid_q || pixel_ready;
	assign take = cmd_valid && cmd_ready;
	assign is_start = cmd.action == ACTION_START;
	// an advance with no line in flight is consumed silently
	assign produce = take && (is_start || active_q);

	always_comb begin
		step_ne = !decision_q[DEC_BITS-1];
		next_x = walk_x_q + coord_t'(1);
		next_y = step_ne ? walk_y_q + coord_t'(1) : walk_y_q;
		next_dec = decision_q + (step_ne ? ne_q : DEC_BITS'(east_q));
		adv_last = next_x >= stop_x_q;
		adv_xy = from_zone0(zone_q, next_x, next_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (pixel_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take && is_start) begin
				active_q <= !cmd.first_last;
			end else if (produce) begin
				active_q <= !adv_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_start) begin
			walk_x_q <= cmd.walk_x;
			walk_y_q <= cmd.walk_y;
			stop_x_q <= cmd.stop_x;
			decision_q <= cmd.decision;
			east_q <= cmd.east_step;
			ne_q <= cmd.ne_step;
			zone_q <= cmd.zone;
			pixel_q <= '{pixel_x: cmd.first_x, pixel_y: cmd.first_y,
				octant: cmd.zone, final_pixel: cmd.first_last};
		end else if (produce) begin
			walk_x_q <= next_x;
			walk_y_q <= next_y;
			decision_q <= next_dec;
			pixel_q <= '{pixel_x: adv_xy.a, pixel_y: adv_xy.b,
				octant: zone_q, final_pixel: adv_last};
		end
	end

	assign pixel_valid = out_valid_q;
	assign pixel = pixel_q;

	a_walk_before_stop: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> walk_x_q < stop_x_q)
		else $error("active line walked past its end");

	a_idle_advance_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !is_start && !active_q) |=> !out_valid_q)
		else $error("advance without a line produced a pixel");

	a_final_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		produce |=> active_q == !pixel_q.final_pixel)
		else $error("line state disagrees with final flag");

endmodule
